// ----- rtl/sorted_deadline_alarm_queue_assert.svh -----
`ifndef SORTED_DEADLINE_ALARM_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_ALARM_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SDAQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SDAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sdaq_pkg.sv -----
package sdaq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 16;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // Logical slot that a read addresses, relative to the walk cursor.
  typedef enum logic [1:0] {
    RD_AT_IDX,
    RD_AFTER_IDX,
    RD_BEFORE_IDX
  } rd_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_t;

  typedef struct packed {
    logic       cap;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_shift;
    logic       wr_new;
    idx_op_t    idx_op;
    logic       pos_load;
    logic       pos_clr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       head_inc;
    logic       head_dec;
    logic       fire_load;
    logic       out_load;
    logic [1:0] out_kind;
    logic [1:0] out_status;
    logic       out_fire;
    logic       out_last;
  } sdaq_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       cnt_zero;
    logic       idx_at_count;
    logic       idx_at_pos;
    logic       idx_at_last;
    logic       head_later;
    logic       entry_not_less;
    logic       tag_hit;
    logic       head_due;
    logic       out_free;
  } sdaq_stat_t;

endpackage

// ----- rtl/sdaq_ifs.sv -----
interface sdaq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] event_time;
  logic [31:0] delay_ticks;
  logic [15:0] alarm_tag;

  modport source(output valid, output opcode, output event_time, output delay_ticks,
                 output alarm_tag, input ready);
  modport sink(input valid, input opcode, input event_time, input delay_ticks,
               input alarm_tag, output ready);
endinterface

interface sdaq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  status;
  logic [15:0] fired_tag;
  logic [4:0]  pending_count;
  logic        last_result;

  modport source(output valid, output result_kind, output status, output fired_tag,
                 output pending_count, output last_result, input ready);
  modport sink(input valid, input result_kind, input status, input fired_tag,
               input pending_count, input last_result, output ready);
endinterface

// ----- rtl/sdaq_ctl.sv -----
module sdaq_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdaq_pkg::sdaq_stat_t st,
  output sdaq_pkg::sdaq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SET_HEAD,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHIFT_TEST,
    S_SHIFT_WR,
    S_INSERT,
    S_CAN_RD,
    S_CAN_CHK,
    S_REM_TEST,
    S_REM_WR,
    S_TICK_RD,
    S_TICK_CHK,
    S_RESP
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic [1:0] resp_r, resp_nxt;
  logic       pending_r, pending_nxt;

  always_comb begin
    state_nxt   = state_r;
    resp_nxt    = resp_r;
    pending_nxt = pending_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap     = 1'b1;
          pending_nxt = 1'b0;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.op)
          sdaq_pkg::OP_SET: begin
            if (st.full) begin
              resp_nxt  = sdaq_pkg::STAT_FULL;
              state_nxt = S_RESP;
            end else if (st.cnt_zero) begin
              cmd.pos_clr = 1'b1;
              state_nxt   = S_INSERT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = sdaq_pkg::RD_AT_IDX;
              state_nxt  = S_SET_HEAD;
            end
          end
          sdaq_pkg::OP_CANCEL: state_nxt = S_CAN_RD;
          sdaq_pkg::OP_TICK:   state_nxt = S_TICK_RD;
          default:             state_nxt = S_IDLE;
        endcase
      end
      S_SET_HEAD: begin
        // head is later than the new alarm: grow the ring backward
        if (st.head_later) begin
          cmd.head_dec = 1'b1;
          cmd.pos_clr  = 1'b1;
          state_nxt    = S_INSERT;
        end else begin
          cmd.idx_op = sdaq_pkg::IDX_INC;
          state_nxt  = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (st.idx_at_count) begin
          cmd.pos_load = 1'b1;
          state_nxt    = S_SHIFT_TEST;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sdaq_pkg::RD_AT_IDX;
          state_nxt  = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (st.entry_not_less) begin
          cmd.pos_load = 1'b1;
          cmd.idx_op   = sdaq_pkg::IDX_COUNT;
          state_nxt    = S_SHIFT_TEST;
        end else begin
          cmd.idx_op = sdaq_pkg::IDX_INC;
          state_nxt  = S_SRCH_RD;
        end
      end
      S_SHIFT_TEST: begin
        if (st.idx_at_pos) begin
          state_nxt = S_INSERT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sdaq_pkg::RD_BEFORE_IDX;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_op   = sdaq_pkg::IDX_DEC;
        state_nxt    = S_SHIFT_TEST;
      end
      S_INSERT: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        resp_nxt    = sdaq_pkg::STAT_OK;
        state_nxt   = S_RESP;
      end
      S_CAN_RD: begin
        if (st.idx_at_count) begin
          resp_nxt  = sdaq_pkg::STAT_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sdaq_pkg::RD_AT_IDX;
          state_nxt  = S_CAN_CHK;
        end
      end
      S_CAN_CHK: begin
        if (st.tag_hit) begin
          state_nxt = S_REM_TEST;
        end else begin
          cmd.idx_op = sdaq_pkg::IDX_INC;
          state_nxt  = S_CAN_RD;
        end
      end
      S_REM_TEST: begin
        // close the gap: pull each later entry one slot toward the head
        if (st.idx_at_last) begin
          cmd.cnt_dec = 1'b1;
          resp_nxt    = sdaq_pkg::STAT_OK;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sdaq_pkg::RD_AFTER_IDX;
          state_nxt  = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_op   = sdaq_pkg::IDX_INC;
        state_nxt    = S_REM_TEST;
      end
      S_TICK_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sdaq_pkg::RD_AT_IDX;
        state_nxt  = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        // hold the popped tag until the next head shows whether it is the last
        if (!pending_r || st.out_free) begin
          if (pending_r) begin
            cmd.out_load   = 1'b1;
            cmd.out_kind   = sdaq_pkg::KIND_FIRED;
            cmd.out_status = sdaq_pkg::STAT_OK;
            cmd.out_fire   = 1'b1;
            cmd.out_last   = !st.head_due;
          end
          if (st.head_due) begin
            cmd.fire_load = 1'b1;
            cmd.head_inc  = 1'b1;
            cmd.cnt_dec   = 1'b1;
            pending_nxt   = 1'b1;
            state_nxt     = S_TICK_RD;
          end else begin
            pending_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = (st.op == sdaq_pkg::OP_CANCEL) ? sdaq_pkg::KIND_CANCEL
                                                          : sdaq_pkg::KIND_SET;
          cmd.out_status = resp_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      resp_r    <= sdaq_pkg::STAT_OK;
      pending_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      resp_r    <= resp_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

// ----- rtl/sdaq_dp.sv -----
module sdaq_dp #(
  parameter int CAPACITY = sdaq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = sdaq_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_opcode,
  input  logic [31:0]         in_event_time,
  input  logic [31:0]         in_delay_ticks,
  input  logic [15:0]         in_alarm_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_result_kind,
  output logic [1:0]          out_status,
  output logic [15:0]         out_fired_tag,
  output logic [4:0]          out_pending_count,
  output logic                out_last_result,
  input  sdaq_pkg::sdaq_cmd_t  cmd,
  output sdaq_pkg::sdaq_stat_t st
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] CAP_W    = SW'(CAPACITY);
  localparam logic [AW-1:0] HEAD_MAX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

  logic [31:0]         dl_mem  [CAPACITY];
  logic [TAG_BITS-1:0] tag_mem [CAPACITY];

  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       pos_r;
  logic [1:0]          op_r;
  logic [31:0]         time_r, delay_r, dl_new_r;
  logic [TAG_BITS-1:0] tag_r, fired_tag_r;
  logic [31:0]         rd_dl_r;
  logic [TAG_BITS-1:0] rd_tag_r;
  logic                out_valid_r;
  logic [1:0]          out_kind_r, out_status_r;
  logic [15:0]         out_tag_r;
  logic [4:0]          out_cnt_r;
  logic                out_last_r;

  logic [CW-1:0]       rd_lg, wr_lg;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [31:0]         wr_dl, offset;
  logic [TAG_BITS-1:0] wr_tag, tag_in;
  logic [TAG_BITS+15:0] tag_in_ext, fired_ext;
  logic [CW+4:0]       cnt_ext;
  logic                out_free;

  // Ring slot of a logical position counted from the head.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                              input logic [CW-1:0] lg);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(lg);
    if (sum >= CAP_W) sum = sum - CAP_W;
    return sum[AW-1:0];
  endfunction

  assign tag_in_ext = {{TAG_BITS{1'b0}}, in_alarm_tag};
  assign tag_in     = tag_in_ext[TAG_BITS-1:0];
  assign fired_ext  = {16'b0, fired_tag_r};
  assign cnt_ext    = {5'b0, count_r};
  assign out_free   = !out_valid_r || out_ready;
  assign offset     = rd_dl_r - time_r;

  always_comb begin
    case (cmd.rd_sel)
      sdaq_pkg::RD_AFTER_IDX:  rd_lg = idx_r + CW'(1);
      sdaq_pkg::RD_BEFORE_IDX: rd_lg = idx_r - CW'(1);
      default:                 rd_lg = idx_r;
    endcase
    wr_lg   = cmd.wr_new ? pos_r : idx_r;
    rd_addr = ring_addr(head_r, rd_lg);
    wr_addr = ring_addr(head_r, wr_lg);
    wr_dl   = cmd.wr_new ? dl_new_r : rd_dl_r;
    wr_tag  = cmd.wr_new ? tag_r : rd_tag_r;
  end

  always_comb begin
    head_nxt = head_r;
    if (cmd.head_inc) begin
      head_nxt = (head_r == HEAD_MAX) ? '0 : head_r + AW'(1);
    end else if (cmd.head_dec) begin
      head_nxt = (head_r == '0) ? HEAD_MAX : head_r - AW'(1);
    end
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
    case (cmd.idx_op)
      sdaq_pkg::IDX_INC:   idx_nxt = idx_r + CW'(1);
      sdaq_pkg::IDX_DEC:   idx_nxt = idx_r - CW'(1);
      sdaq_pkg::IDX_COUNT: idx_nxt = count_r;
      default:             idx_nxt = idx_r;
    endcase
    if (cmd.cap) idx_nxt = '0;
  end

  always_comb begin
    st.op             = op_r;
    st.full           = (count_r == CNT_FULL);
    st.cnt_zero       = (count_r == '0);
    st.idx_at_count   = (idx_r == count_r);
    st.idx_at_pos     = (idx_r == pos_r);
    st.idx_at_last    = ((idx_r + CW'(1)) == count_r);
    st.head_later     = (offset > delay_r);
    st.entry_not_less = (offset >= delay_r);
    st.tag_hit        = (rd_tag_r == tag_r);
    st.head_due       = (count_r != '0) && (rd_dl_r == time_r);
    st.out_free       = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_dl_r  <= dl_mem[rd_addr];
      rd_tag_r <= tag_mem[rd_addr];
    end
    if (cmd.wr_shift || cmd.wr_new) begin
      dl_mem[wr_addr]  <= wr_dl;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.cap) begin
      op_r     <= in_opcode;
      time_r   <= in_event_time;
      delay_r  <= in_delay_ticks;
      dl_new_r <= in_event_time + in_delay_ticks;
      tag_r    <= tag_in;
    end
    if (cmd.pos_clr) begin
      pos_r <= '0;
    end else if (cmd.pos_load) begin
      pos_r <= idx_r;
    end
    if (cmd.fire_load) fired_tag_r <= rd_tag_r;
    if (cmd.out_load) begin
      out_kind_r   <= cmd.out_kind;
      out_status_r <= cmd.out_status;
      out_tag_r    <= cmd.out_fire ? fired_ext[15:0] : 16'd0;
      out_cnt_r    <= cnt_ext[4:0];
      out_last_r   <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_status        = out_status_r;
  assign out_fired_tag     = out_tag_r;
  assign out_pending_count = out_cnt_r;
  assign out_last_result   = out_last_r;

endmodule

// ----- rtl/sorted_deadline_alarm_queue.sv -----
// Sorted alarm queue on a ring buffer, one memory read and one write per step.
// A set checks the head, then searches on and shifts the tail; a cancel searches
// by tag, then closes the gap; a tick pops head alarms whose deadline is now.
// One item at a time; a final result loads the output register as in_ch.ready
// returns, and a held result stalls the tick walk and the response until taken.
// Reset (synchronous, rst_n low) empties the queue and drops any held result.
module sorted_deadline_alarm_queue #(
  parameter int CAPACITY = sdaq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = sdaq_pkg::TAG_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sdaq_in_if.sink    in_ch,
  sdaq_out_if.source out_ch
);

  sdaq_pkg::sdaq_cmd_t  cmd;
  sdaq_pkg::sdaq_stat_t st;

  sdaq_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  sdaq_dp #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_ch.opcode),
    .in_event_time     (in_ch.event_time),
    .in_delay_ticks    (in_ch.delay_ticks),
    .in_alarm_tag      (in_ch.alarm_tag),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_result_kind   (out_ch.result_kind),
    .out_status        (out_ch.status),
    .out_fired_tag     (out_ch.fired_tag),
    .out_pending_count (out_ch.pending_count),
    .out_last_result   (out_ch.last_result),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

// ----- rtl/sdaq_checker.sv -----
`include "sorted_deadline_alarm_queue_assert.svh"

module sdaq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [1:0]  status,
  input logic [15:0] fired_tag,
  input logic [4:0]  pending_count,
  input logic        last_result
);

  `SDAQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(status) && $stable(fired_tag) && $stable(pending_count) && $stable(last_result), "result changed while stalled")
  `SDAQ_ASSERT_SAME(a_ack_single, out_valid && result_kind != sdaq_pkg::KIND_FIRED, last_result && fired_tag == 16'd0, "acknowledge not single or carries a tag")
  `SDAQ_ASSERT_SAME(a_fire_ok, out_valid && result_kind == sdaq_pkg::KIND_FIRED, status == sdaq_pkg::STAT_OK, "fired alarm with nonzero status")
  `SDAQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second item taken while one is at work")

endmodule

bind sorted_deadline_alarm_queue sdaq_checker u_sdaq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .result_kind   (out_ch.result_kind),
  .status        (out_ch.status),
  .fired_tag     (out_ch.fired_tag),
  .pending_count (out_ch.pending_count),
  .last_result   (out_ch.last_result)
);
